// ===== hw/rtl/dbcw_pkg.sv =====
`timescale 1ns / 1ps
package dbcw_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned TableAw = $clog2(TableDepth);

  localparam logic [1:0] OpSent    = 2'd0;
  localparam logic [1:0] OpAck     = 2'd1;
  localparam logic [1:0] OpTimeout = 2'd2;

  localparam logic CfgDefaultDelay = 1'b0;
  localparam logic CfgWindowFloor  = 1'b1;

  localparam logic [15:0] DefaultDelayReset = 16'd200;
  localparam logic [7:0]  WindowFloorReset  = 8'd5;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StClear = 7'b0000010,
    StRead  = 7'b0000100,
    StAck   = 7'b0001000,
    StDiv   = 7'b0010000,
    StTmo   = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  // Saturating increment of a 16-bit window.
  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    logic [15:0] r;
    r = (v == 16'hFFFF) ? v : v + 16'd1;
    return r;
  endfunction

endpackage

// ===== hw/rtl/dbcw_ram.sv =====
`timescale 1ns / 1ps
module dbcw_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hw/rtl/delay_based_congestion_window.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Signals
// command | in        | start_i, busy_o, opcode_i, seq_num_i, sent_time_ms_i, ack_time_ms_i
// config  | in        | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i
// result  | out       | done_o, window_out_o, timeout_out_ms_o
// A send or timeout passes through the read, timeout and output states before the
// result; an ack also passes through the ack update, and through the 32-step
// remainder unit when the window divisibility test runs.
// After reset all 1024 words of the window table are cleared, one word a cycle;
// busy is high meanwhile, configuration writes are still taken.
// The result word is shown for one cycle with done; the receiver cannot stall.
module delay_based_congestion_window (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] seq_num_i,
  input  logic [31:0] sent_time_ms_i,
  input  logic [31:0] ack_time_ms_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        done_o,
  output logic [15:0] window_out_o,
  output logic [31:0] timeout_out_ms_o
);

  localparam int unsigned Aw = dbcw_pkg::TableAw;

  dbcw_pkg::state_e state_q, state_d;

  logic [15:0] dflt_q;
  logic [7:0]  floor_q;
  logic [15:0] cwnd_q, cwnd_d, est_q, est_d, saved_q, saved_d;
  logic        probing_q, probing_d, recov_q, recov_d;
  logic [31:0] rlimit_q, rlimit_d, mind_q, mind_d;
  logic [Aw:0] clr_q, clr_d;

  logic [1:0]  op_q;
  logic [31:0] seq_q, delay_q, delay_d;
  logic [31:0] rem_q, rem_d;
  logic [5:0]  dcnt_q, dcnt_d;
  logic [34:0] tmo_q, tmo_d;
  logic        done_q, done_d;

  logic          we;
  logic [Aw-1:0] waddr, raddr;
  logic [15:0]   wdata, rdata;

  assign cfg_ready_o = 1'b1;
  assign busy_o = (state_q != dbcw_pkg::StIdle);
  assign done_o = done_q;
  assign window_out_o = cwnd_q;
  assign timeout_out_ms_o = tmo_q[34:32] != 3'd0 ? 32'hFFFF_FFFF : tmo_q[31:0];

  dbcw_ram #(.Width(16), .Depth(dbcw_pkg::TableDepth)) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Combinational datapath terms.
  logic [31:0] raw_delay, eff_delay, new_min;
  logic [33:0] lhs, rhs;
  logic [32:0] trial;
  logic [17:0] est3;
  logic [18:0] cw5;
  logic [15:0] s58;
  logic [15:0] tbl, pe_cwnd, pe_est;

  always_comb begin
    raw_delay = ack_time_ms_i - sent_time_ms_i;
    eff_delay = (raw_delay == 32'd0) ? {16'd0, dflt_q} : raw_delay;
    new_min   = (delay_q < mind_q) ? delay_q : mind_q;
    lhs       = {1'b0, delay_q, 1'b0};
    rhs       = {2'b0, new_min} + {1'b0, new_min, 1'b0};
    tbl       = (rdata == 16'd0) ? {8'd0, floor_q} : rdata;
    est3      = {2'b0, tbl} + {1'b0, tbl, 1'b0};
    cw5       = {3'b0, cwnd_q} + {1'b0, cwnd_q, 2'b0};
    s58       = cw5[18:3];
    trial     = {rem_q, seq_q[dcnt_q[4:0]]} - {17'd0, cwnd_q};
    // Leaving probe mode restores the saved window.
    pe_cwnd   = probing_q ? saved_q : cwnd_q;
    pe_est    = probing_q ? saved_q : est_q;
  end

  // Sequencer: clear, table read, ack update, remainder test, timeout math.
  always_comb begin
    state_d = state_q;
    cwnd_d = cwnd_q; est_d = est_q; saved_d = saved_q;
    probing_d = probing_q; recov_d = recov_q;
    rlimit_d = rlimit_q; mind_d = mind_q; clr_d = clr_q;
    delay_d = delay_q; rem_d = rem_q; dcnt_d = dcnt_q;
    tmo_d = tmo_q; done_d = 1'b0;
    we = 1'b0; waddr = seq_q[Aw-1:0]; wdata = cwnd_q;
    raddr = seq_q[Aw-1:0];
    case (state_q)
      dbcw_pkg::StClear: begin
        we = 1'b1;
        waddr = clr_q[Aw-1:0];
        wdata = 16'd0;
        clr_d = clr_q + 1'b1;
        if (clr_q[Aw-1:0] == {Aw{1'b1}}) begin
          state_d = dbcw_pkg::StIdle;
        end
      end
      dbcw_pkg::StIdle: begin
        if (start_i) begin
          delay_d = eff_delay;
          state_d = dbcw_pkg::StRead;
        end
      end
      dbcw_pkg::StRead: begin
        state_d = dbcw_pkg::StTmo;
        case (op_q)
          dbcw_pkg::OpSent: begin
            we = 1'b1;
            if (!recov_q) begin
              rlimit_d = seq_q;
            end
          end
          dbcw_pkg::OpAck: begin
            state_d = dbcw_pkg::StAck;
          end
          dbcw_pkg::OpTimeout: begin
            probing_d = 1'b1;
            if (saved_q == 16'd0) begin
              saved_d = (s58 > {8'd0, floor_q}) ? s58 : 16'd1;
            end
            cwnd_d = 16'd0;
          end
          default: ;
        endcase
      end
      dbcw_pkg::StAck: begin
        state_d = dbcw_pkg::StTmo;
        probing_d = 1'b0;
        mind_d = new_min;
        cwnd_d = pe_cwnd;
        est_d = pe_est;
        if (probing_q) begin
          saved_d = 16'd0;
        end
        if ((recov_q || probing_q) && seq_q <= rlimit_q) begin
          recov_d = 1'b1;
          if (pe_cwnd != 16'd0) begin
            rem_d = 32'd0;
            dcnt_d = 6'd31;
            state_d = dbcw_pkg::StDiv;
          end
        end else begin
          recov_d = 1'b0;
          if (lhs <= rhs) begin
            cwnd_d = dbcw_pkg::sat_inc16(pe_cwnd);
            if (pe_est < cwnd_d) begin
              est_d = cwnd_d;
            end
          end else if (pe_cwnd >= pe_est) begin
            est_d = tbl;
            cwnd_d = (est3[17:2] == 16'd0) ? {8'd0, floor_q} : est3[17:2];
          end else begin
            est_d = (pe_est[15:1] == 15'd0) ? {8'd0, floor_q} : {1'b0, pe_est[15:1]};
          end
        end
      end
      dbcw_pkg::StDiv: begin
        // Restoring remainder, one bit of seq_num a cycle.
        rem_d = trial[32] ? {rem_q[30:0], seq_q[dcnt_q[4:0]]} : trial[31:0];
        dcnt_d = dcnt_q - 6'd1;
        if (dcnt_q == 6'd0) begin
          state_d = dbcw_pkg::StTmo;
          if (rem_d == 32'd0) begin
            cwnd_d = dbcw_pkg::sat_inc16(cwnd_q);
            est_d = cwnd_d;
          end
        end
      end
      dbcw_pkg::StTmo: begin
        tmo_d = {1'b0, mind_q, 2'b0} + {2'b0, mind_q, 1'b0};
        state_d = dbcw_pkg::StOut;
      end
      dbcw_pkg::StOut: begin
        // Divide by 5 as multiply by ceil(2^34/5) on the 6x product.
        if (probing_q) begin
          tmo_d = 35'((({32'd0, tmo_q[34:0]} * 67'd3435973837) >> 34));
        end
        done_d = 1'b1;
        state_d = dbcw_pkg::StIdle;
      end
      default: state_d = dbcw_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dbcw_pkg::StClear;
      dflt_q <= dbcw_pkg::DefaultDelayReset;
      floor_q <= dbcw_pkg::WindowFloorReset;
      cwnd_q <= 16'd1;
      est_q <= 16'd10;
      saved_q <= 16'd0;
      probing_q <= 1'b0;
      recov_q <= 1'b0;
      rlimit_q <= 32'd0;
      mind_q <= {16'd0, dbcw_pkg::DefaultDelayReset};
      clr_q <= '0;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cwnd_q <= cwnd_d;
      est_q <= est_d;
      saved_q <= saved_d;
      probing_q <= probing_d;
      recov_q <= recov_d;
      rlimit_q <= rlimit_d;
      mind_q <= mind_d;
      clr_q <= clr_d;
      done_q <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == dbcw_pkg::CfgDefaultDelay) begin
          dflt_q <= cfg_data_i;
        end else begin
          floor_q <= cfg_data_i[7:0];
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == dbcw_pkg::StIdle && start_i) begin
      op_q <= opcode_i;
      seq_q <= seq_num_i;
    end
    delay_q <= delay_d;
    rem_q <= rem_d;
    dcnt_q <= dcnt_d;
    tmo_q <= tmo_d;
  end

  a_done_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == dbcw_pkg::StOut)) else $error("done without finish");
  a_timeout_zero_win: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dbcw_pkg::StRead && op_q == dbcw_pkg::OpTimeout) |=> cwnd_q == 16'd0)
    else $error("timeout kept window");
  a_min_delay_falls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != dbcw_pkg::StAck |=> mind_q == $past(mind_q)) else $error("min delay moved");
  a_probe_saved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dbcw_pkg::StTmo && probing_q) |-> saved_q != 16'd0)
    else $error("probing without saved window");

endmodule
